// ===== rtl/llc_pkg.sv =====
// Package: opcodes, widths and shared types for the linked-list cursor engine.
`timescale 1ns / 1ps
package llc_pkg;
  localparam int POOL_DEPTH_DEF = 16;
  localparam int OPC_W = 4;
  localparam int VAL_W = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_CLEAR        = 4'd0,
    OP_INSERT_HEAD  = 4'd1,
    OP_CURSOR_HEAD  = 4'd2,
    OP_READ_HEAD    = 4'd3,
    OP_DELETE_HEAD  = 4'd4,
    OP_DELETE_AFTER = 4'd5,
    OP_INSERT_AFTER = 4'd6,
    OP_READ_CURSOR  = 4'd7,
    OP_WRITE_CURSOR = 4'd8,
    OP_ADVANCE      = 4'd9,
    OP_NONE         = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    op_t          op;
    logic [VAL_W-1:0] value;
  } cmd_t;
endpackage

// ===== rtl/llc_front.sv =====
// Front end: accept requests, classify opcodes and queue commands.
`timescale 1ns / 1ps
module llc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              in_opcode,
  input  logic signed [31:0]      in_value,
  output logic                    q_valid,
  output llc_pkg::cmd_t           q_cmd,
  input  logic                    q_take
);
  llc_pkg::cmd_t q_mem_r [llc_pkg::QUEUE_DEPTH];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  llc_pkg::cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.value = in_value;
    case (in_opcode)
      llc_pkg::OP_CLEAR:        cmd_in.op = llc_pkg::OP_CLEAR;
      llc_pkg::OP_INSERT_HEAD:  cmd_in.op = llc_pkg::OP_INSERT_HEAD;
      llc_pkg::OP_CURSOR_HEAD:  cmd_in.op = llc_pkg::OP_CURSOR_HEAD;
      llc_pkg::OP_READ_HEAD:    cmd_in.op = llc_pkg::OP_READ_HEAD;
      llc_pkg::OP_DELETE_HEAD:  cmd_in.op = llc_pkg::OP_DELETE_HEAD;
      llc_pkg::OP_DELETE_AFTER: cmd_in.op = llc_pkg::OP_DELETE_AFTER;
      llc_pkg::OP_INSERT_AFTER: cmd_in.op = llc_pkg::OP_INSERT_AFTER;
      llc_pkg::OP_READ_CURSOR:  cmd_in.op = llc_pkg::OP_READ_CURSOR;
      llc_pkg::OP_WRITE_CURSOR: cmd_in.op = llc_pkg::OP_WRITE_CURSOR;
      llc_pkg::OP_ADVANCE:      cmd_in.op = llc_pkg::OP_ADVANCE;
      default: cmd_in.op = llc_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (q_cnt_r == 2'(llc_pkg::QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_cmd = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wp_r] <= cmd_in;
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/llc_back.sv =====
// Back end: node pool, allocator and list operations with a result register.
`timescale 1ns / 1ps
module llc_back #(
  parameter int POOL_DEPTH = llc_pkg::POOL_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  llc_pkg::cmd_t        q_cmd,
  output logic                 q_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_read_value,
  output logic                 out_error,
  output logic                 out_cursor_active
);
  localparam int IW = $clog2(POOL_DEPTH);
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  logic [31:0]   val_mem [POOL_DEPTH];
  logic [PW-1:0] link_mem [POOL_DEPTH];
  logic [IW-1:0] stk_mem [POOL_DEPTH];

  llc_pkg::state_t state_r, state_nxt;
  llc_pkg::cmd_t cmd_r;
  logic [PW-1:0] head_r, head_nxt, cur_r, cur_nxt, fresh_r, fresh_nxt;
  logic [PW-1:0] rcnt_r, rcnt_nxt;
  // Registered reads from the fetch cycle.
  logic [31:0]   hval_r, cval_r;
  logic [PW-1:0] hlink_r, clink_r, nlink_r;
  logic [IW-1:0] stop_r;
  logic [PW-1:0] nlink_addr;

  logic          res_v_r;
  logic [31:0]   res_val_r, res_val_nxt;
  logic          res_err_r, res_err_nxt;
  logic          res_cur_r;

  logic head_ok, cur_ok, nxt_ok, have_rec, have_fresh, can_take;
  logic [IW-1:0] new_idx;
  logic          vw_en, lw_en, lw2_en, sw_en;
  logic [IW-1:0] vw_a, lw_a, lw2_a, sw_a;
  logic [31:0]   vw_d;
  logic [PW-1:0] lw_d, lw2_d;
  logic [IW-1:0] sw_d;
  logic          do_exec;

  assign head_ok = head_r < NIL;
  assign cur_ok  = cur_r < NIL;
  assign nxt_ok  = clink_r < NIL;
  assign have_rec = (rcnt_r != '0);
  assign have_fresh = fresh_r < NIL;
  assign can_take = have_rec || have_fresh;
  assign new_idx = have_rec ? stop_r : fresh_r[IW-1:0];
  assign nlink_addr = link_mem[cur_r[IW-1:0]];

  assign q_take = (state_r == llc_pkg::ST_IDLE) && q_valid;
  assign do_exec = (state_r == llc_pkg::ST_EXEC) && !(res_v_r && out_stall);

  always_comb begin
    case (state_r)
      llc_pkg::ST_IDLE:  state_nxt = q_valid ? llc_pkg::ST_FETCH : llc_pkg::ST_IDLE;
      llc_pkg::ST_FETCH: state_nxt = llc_pkg::ST_EXEC;
      llc_pkg::ST_EXEC:  state_nxt = do_exec ? llc_pkg::ST_IDLE : llc_pkg::ST_EXEC;
      default:           state_nxt = llc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt = head_r; cur_nxt = cur_r; fresh_nxt = fresh_r; rcnt_nxt = rcnt_r;
    res_val_nxt = '0; res_err_nxt = 1'b0;
    vw_en = 1'b0; vw_a = new_idx; vw_d = cmd_r.value;
    lw_en = 1'b0; lw_a = new_idx; lw_d = head_r;
    lw2_en = 1'b0; lw2_a = cur_r[IW-1:0]; lw2_d = PW'(new_idx);
    sw_en = 1'b0; sw_a = rcnt_r[IW-1:0]; sw_d = head_r[IW-1:0];
    case (cmd_r.op)
      llc_pkg::OP_CLEAR: begin
        head_nxt = NIL; cur_nxt = NIL; fresh_nxt = '0; rcnt_nxt = '0;
      end
      llc_pkg::OP_INSERT_HEAD: begin
        if (!can_take) res_err_nxt = 1'b1;
        else begin
          vw_en = 1'b1; lw_en = 1'b1; head_nxt = PW'(new_idx);
          if (have_rec) rcnt_nxt = rcnt_r - PW'(1);
          else fresh_nxt = fresh_r + PW'(1);
        end
      end
      llc_pkg::OP_CURSOR_HEAD: cur_nxt = head_r;
      llc_pkg::OP_READ_HEAD: begin
        if (head_ok) res_val_nxt = hval_r;
        else res_err_nxt = 1'b1;
      end
      llc_pkg::OP_DELETE_HEAD: begin
        if (head_ok) begin
          if (cur_r == head_r) cur_nxt = NIL;
          head_nxt = hlink_r;
          if (rcnt_r < NIL) begin
            sw_en = 1'b1; rcnt_nxt = rcnt_r + PW'(1);
          end
        end
      end
      llc_pkg::OP_DELETE_AFTER: begin
        if (cur_ok && nxt_ok) begin
          lw_en = 1'b1; lw_a = cur_r[IW-1:0]; lw_d = nlink_r;
          if (rcnt_r < NIL) begin
            sw_en = 1'b1; sw_d = clink_r[IW-1:0]; rcnt_nxt = rcnt_r + PW'(1);
          end
        end
      end
      llc_pkg::OP_INSERT_AFTER: begin
        if (cur_ok) begin
          if (!can_take) res_err_nxt = 1'b1;
          else begin
            vw_en = 1'b1; lw_en = 1'b1; lw_d = clink_r;
            lw2_en = 1'b1;
            if (have_rec) rcnt_nxt = rcnt_r - PW'(1);
            else fresh_nxt = fresh_r + PW'(1);
          end
        end
      end
      llc_pkg::OP_READ_CURSOR: begin
        if (cur_ok) res_val_nxt = cval_r;
        else res_err_nxt = 1'b1;
      end
      llc_pkg::OP_WRITE_CURSOR: begin
        if (cur_ok) begin
          vw_en = 1'b1; vw_a = cur_r[IW-1:0];
        end
      end
      llc_pkg::OP_ADVANCE: if (cur_ok) cur_nxt = clink_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take) cmd_r <= q_cmd;
    if (state_r == llc_pkg::ST_FETCH) begin
      hval_r  <= val_mem[head_r[IW-1:0]];
      hlink_r <= link_mem[head_r[IW-1:0]];
      cval_r  <= val_mem[cur_r[IW-1:0]];
      clink_r <= nlink_addr;
      nlink_r <= link_mem[nlink_addr[IW-1:0]];
      stop_r  <= stk_mem[rcnt_r[IW-1:0] - IW'(1)];
    end
    if (do_exec) begin
      if (vw_en) val_mem[vw_a] <= vw_d;
      if (lw_en) link_mem[lw_a] <= lw_d;
      if (lw2_en) link_mem[lw2_a] <= lw2_d;
      if (sw_en) stk_mem[sw_a] <= sw_d;
      res_val_r <= res_val_nxt;
      res_err_r <= res_err_nxt;
    end
    if (!rst_n) begin
      state_r <= llc_pkg::ST_IDLE;
      head_r <= NIL; cur_r <= NIL; fresh_r <= '0; rcnt_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_exec) begin
        head_r <= head_nxt; cur_r <= cur_nxt; fresh_r <= fresh_nxt; rcnt_r <= rcnt_nxt;
      end
      if (do_exec) res_v_r <= 1'b1;
      else if (!out_stall) res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) if (do_exec) res_cur_r <= (cur_nxt < NIL);

  assign out_valid = res_v_r;
  assign out_read_value = res_val_r;
  assign out_error = res_err_r;
  assign out_cursor_active = res_cur_r;
endmodule

// ===== rtl/linked_list_cursor_engine_top.sv =====
// Top level: singly linked list with cursor, front queue plus list back end.
// A request passes the front queue, then the back end's fetch and execute
// states; the back end takes a new one only after the last leaves execute,
// held by out_stall. Fetch reads node memories (two dependent link reads).
// Reset: synchronous active-low rst_n empties the list, nulls head and
// cursor and clears both allocators; node memories need no clearing pass.
`timescale 1ns / 1ps
module linked_list_cursor_engine_top #(
  parameter int POOL_DEPTH = llc_pkg::POOL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic               out_error,
  output logic               out_cursor_active
);
  // Command queue between classifier and executor.
  logic q_valid, q_take;
  llc_pkg::cmd_t q_cmd;

  llc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_value,
    .q_valid, .q_cmd, .q_take
  );

  llc_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take,
    .out_valid, .out_stall, .out_read_value, .out_error, .out_cursor_active
  );

  // A stalled result must hold its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_error))
    else $error("result changed under stall");
  // A failed read or insert never reports data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_read_value == 32'sd0)
    else $error("error result carries data");
  // Queue pop only when the queue holds something.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("pop from empty queue");
endmodule
